@@ rtl/enacc_pkg.sv @@
// ----------------------------------------------------------------------------
// enacc_pkg
// Shared constants and the result job type of the error norm accumulator.
// ----------------------------------------------------------------------------
package enacc_pkg;

    // Fixed widths of the payload fields.
    localparam int FIELD_W = 24;
    localparam int COUNT_W = 13;

    // Defaults for the top level parameters.
    localparam int DEF_MAX_ITEMS   = 4096;
    localparam int DEF_VALUE_WIDTH = 24;

    // Job fields are sized for the largest legal parameter values.
    localparam int JOB_ABS_W = FIELD_W + COUNT_W;
    localparam int JOB_SQ_W  = 2 * FIELD_W + COUNT_W;

    // Entries in the queue between the accumulator and the divide/root unit.
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [JOB_ABS_W-1:0] abs_sum;
        logic [JOB_SQ_W-1:0]  square_sum;
        logic [FIELD_W-1:0]   max_abs;
        logic [COUNT_W-1:0]   count;
        logic                 overflow;
    } t_job;

endpackage

@@ rtl/enacc_front.sv @@
// ----------------------------------------------------------------------------
// enacc_front
// Accepts sample pairs, forms the magnitude and square of each difference in
// a short pipeline and accumulates them; a last pair hands a job to the queue.
// ----------------------------------------------------------------------------
module enacc_front #(
    parameter int VALUE_WIDTH = 24,
    parameter int MAX_ITEMS   = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [enacc_pkg::FIELD_W-1:0] i_computed_value,
    input  logic [enacc_pkg::FIELD_W-1:0] i_exact_value,
    input  logic                          i_last_item,
    output logic                          o_push,
    output enacc_pkg::t_job               o_job,
    input  logic                          i_q_ready
);
    import enacc_pkg::*;

    localparam int VW    = VALUE_WIDTH;
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int ABS_W = VW + CNT_W;
    localparam int SQ_W  = 2 * VW + CNT_W;

    logic             advance;
    logic             accept;
    logic [VW:0]      diff;
    logic [VW:0]      neg_diff;
    logic [VW-1:0]    mag;
    logic             keep;
    logic [CNT_W-1:0] cnt_inc;

    logic [CNT_W-1:0] r_cnt;
    logic             r_ovf;

    logic             r_s1_valid, r_s1_last, r_s1_keep, r_s1_ovf;
    logic [VW-1:0]    r_s1_mag;
    logic [CNT_W-1:0] r_s1_cnt;

    logic             r_s2_valid, r_s2_last, r_s2_keep, r_s2_ovf;
    logic [VW-1:0]    r_s2_mag;
    logic [2*VW-1:0]  r_s2_sq;
    logic [CNT_W-1:0] r_s2_cnt;

    logic [ABS_W-1:0] r_abs, n_abs;
    logic [SQ_W-1:0]  r_sq, n_sq;
    logic [VW-1:0]    r_max, n_max;

    // The whole pipeline holds while a finished set cannot enter the queue.
    assign advance = !(r_s2_valid && r_s2_last && !i_q_ready);
    assign o_ready = advance;
    assign accept  = i_valid && advance;

    assign diff     = {i_computed_value[VW-1], i_computed_value[VW-1:0]}
                    - {i_exact_value[VW-1], i_exact_value[VW-1:0]};
    assign neg_diff = -diff;
    assign mag      = diff[VW] ? neg_diff[VW-1:0] : diff[VW-1:0];

    assign keep    = r_cnt < CNT_W'(MAX_ITEMS);
    assign cnt_inc = r_cnt + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (accept) begin
            if (i_last_item) begin
                r_cnt <= '0;
                r_ovf <= 1'b0;
            end else begin
                r_cnt <= keep ? cnt_inc : r_cnt;
                r_ovf <= r_ovf | !keep;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= accept;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_mag  <= mag;
            r_s1_last <= i_last_item;
            r_s1_keep <= keep;
            r_s1_cnt  <= keep ? cnt_inc : r_cnt;
            r_s1_ovf  <= r_ovf | !keep;
            r_s2_mag  <= r_s1_mag;
            r_s2_sq   <= r_s1_mag * r_s1_mag;
            r_s2_last <= r_s1_last;
            r_s2_keep <= r_s1_keep;
            r_s2_cnt  <= r_s1_cnt;
            r_s2_ovf  <= r_s1_ovf;
        end
    end

    always_comb begin
        n_abs = r_abs;
        n_sq  = r_sq;
        n_max = r_max;
        if (r_s2_keep) begin
            n_abs = r_abs + ABS_W'(r_s2_mag);
            n_sq  = r_sq + SQ_W'(r_s2_sq);
            n_max = (r_s2_mag > r_max) ? r_s2_mag : r_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_abs <= '0;
            r_sq  <= '0;
            r_max <= '0;
        end else if (advance && r_s2_valid) begin
            if (r_s2_last) begin
                r_abs <= '0;
                r_sq  <= '0;
                r_max <= '0;
            end else begin
                r_abs <= n_abs;
                r_sq  <= n_sq;
                r_max <= n_max;
            end
        end
    end

    assign o_push           = advance && r_s2_valid && r_s2_last;
    assign o_job.abs_sum    = JOB_ABS_W'(n_abs);
    assign o_job.square_sum = JOB_SQ_W'(n_sq);
    assign o_job.max_abs    = FIELD_W'(n_max);
    assign o_job.count      = COUNT_W'(r_s2_cnt);
    assign o_job.overflow   = r_s2_ovf;

endmodule

@@ rtl/enacc_queue.sv @@
// ----------------------------------------------------------------------------
// enacc_queue
// Small register queue of finished sets waiting for the divide/root unit.
// ----------------------------------------------------------------------------
module enacc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  enacc_pkg::t_job i_job,
    output logic            o_ready,
    output logic            o_valid,
    output enacc_pkg::t_job o_job,
    input  logic            i_pop
);
    import enacc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [LVL_W-1:0] r_level;
    logic             do_push, do_pop;

    assign o_ready = r_level != LVL_W'(QUEUE_DEPTH);
    assign o_valid = r_level != '0;
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_level <= r_level + LVL_W'(1);
            end else if (do_pop && !do_push) begin
                r_level <= r_level - LVL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

@@ rtl/enacc_back.sv @@
// ----------------------------------------------------------------------------
// enacc_back
// Turns one finished set into norms: a shared bit-serial divider gives the
// two means, a digit-by-digit square root gives the RMS value.
// ----------------------------------------------------------------------------
module enacc_back #(
    parameter int VALUE_WIDTH = 24,
    parameter int MAX_ITEMS   = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_job_valid,
    input  enacc_pkg::t_job               i_job,
    output logic                          o_job_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [enacc_pkg::FIELD_W-1:0] o_mean_abs_error,
    output logic [enacc_pkg::FIELD_W-1:0] o_rms_error,
    output logic [enacc_pkg::FIELD_W-1:0] o_max_abs_error,
    output logic [enacc_pkg::COUNT_W-1:0] o_pair_count,
    output logic                          o_count_overflow
);
    import enacc_pkg::*;

    localparam int VW     = VALUE_WIDTH;
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int ABS_W  = VW + CNT_W;
    localparam int SQ_W   = 2 * VW + CNT_W;
    localparam int STEP_W = $clog2(SQ_W);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_SQRT = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state            r_state;
    logic              r_pass;
    logic [STEP_W-1:0] r_step;
    logic [SQ_W-1:0]   r_quo, n_quo;
    logic [CNT_W-1:0]  r_rem, n_rem;
    logic [CNT_W-1:0]  r_div;
    logic [SQ_W-1:0]   r_sq_hold;
    logic [VW-1:0]     r_mean;
    logic [VW-1:0]     r_max;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_ovf;
    logic [2*VW-1:0]   r_rad;
    logic [VW:0]       r_srem, n_srem;
    logic [VW-1:0]     r_root, n_root;

    logic              r_o_valid;
    logic [VW-1:0]     r_o_mean, r_o_rms, r_o_max;
    logic [CNT_W-1:0]  r_o_cnt;
    logic              r_o_ovf;

    logic [CNT_W:0]    rem_sh;
    logic              div_ge;
    logic [VW+2:0]     sq_t, sq_trial;
    logic              sq_ge;
    logic              out_free;

    // One restoring divide step per cycle.
    always_comb begin
        rem_sh = {r_rem, r_quo[SQ_W-1]};
        div_ge = rem_sh >= {1'b0, r_div};
        n_rem  = div_ge ? CNT_W'(rem_sh - {1'b0, r_div}) : rem_sh[CNT_W-1:0];
        n_quo  = {r_quo[SQ_W-2:0], div_ge};
    end

    // One root bit per cycle from two radicand bits.
    always_comb begin
        sq_t     = {r_srem, r_rad[2*VW-1 -: 2]};
        sq_trial = {1'b0, r_root, 2'b01};
        sq_ge    = sq_t >= sq_trial;
        n_srem   = sq_ge ? (VW+1)'(sq_t - sq_trial) : sq_t[VW:0];
        n_root   = {r_root[VW-2:0], sq_ge};
    end

    assign out_free  = !r_o_valid || i_ready;
    assign o_job_pop = (r_state == S_IDLE) && i_job_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_step == STEP_W'(SQ_W - 1) && r_pass) begin
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (r_step == STEP_W'(VW - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_quo     <= SQ_W'(i_job.abs_sum[ABS_W-1:0]);
                r_rem     <= '0;
                r_div     <= i_job.count[CNT_W-1:0];
                r_sq_hold <= i_job.square_sum[SQ_W-1:0];
                r_max     <= i_job.max_abs[VW-1:0];
                r_cnt     <= i_job.count[CNT_W-1:0];
                r_ovf     <= i_job.overflow;
                r_pass    <= 1'b0;
                r_step    <= '0;
            end
            S_DIV: begin
                if (r_step == STEP_W'(SQ_W - 1)) begin
                    r_step <= '0;
                    if (!r_pass) begin
                        // Mean absolute error done; reuse the divider for squares.
                        r_mean <= n_quo[VW-1:0];
                        r_quo  <= r_sq_hold;
                        r_rem  <= '0;
                        r_pass <= 1'b1;
                    end else begin
                        r_rad  <= n_quo[2*VW-1:0];
                        r_srem <= '0;
                        r_root <= '0;
                    end
                end else begin
                    r_quo  <= n_quo;
                    r_rem  <= n_rem;
                    r_step <= r_step + STEP_W'(1);
                end
            end
            S_SQRT: begin
                r_srem <= n_srem;
                r_root <= n_root;
                r_rad  <= {r_rad[2*VW-3:0], 2'b00};
                r_step <= r_step + STEP_W'(1);
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_o_mean <= r_mean;
            r_o_rms  <= r_root;
            r_o_max  <= r_max;
            r_o_cnt  <= r_cnt;
            r_o_ovf  <= r_ovf;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_mean_abs_error = FIELD_W'(r_o_mean);
    assign o_rms_error      = FIELD_W'(r_o_rms);
    assign o_max_abs_error  = FIELD_W'(r_o_max);
    assign o_pair_count     = COUNT_W'(r_o_cnt);
    assign o_count_overflow = r_o_ovf;

endmodule

@@ rtl/error_norm_accumulator.sv @@
// ----------------------------------------------------------------------------
// error_norm_accumulator
// Mean absolute, RMS and maximum error of sets of signed Q8.16 sample pairs.
// ----------------------------------------------------------------------------
//  Channel  | Handshake          | Payload
//  ---------+--------------------+--------------------------------------------
//  input    | i_valid / o_ready  | i_computed_value, i_exact_value, i_last_item
//  output   | o_valid / i_ready  | o_mean_abs_error, o_rms_error,
//           |                    | o_max_abs_error, o_pair_count,
//           |                    | o_count_overflow
//
// The accumulator takes one pair per cycle while o_ready is high. A set's
// result is offered once the divide/root unit has taken it from the queue,
// divided both sums and taken the root. That unit works on one set at a time
// with its shared one-bit-per-cycle divider and one-bit-per-cycle root.
// Up to QUEUE_DEPTH finished sets wait between the two; input stalls only when
// that queue is full and a last pair reaches the accumulator.
// Reset is synchronous and clears all sums, counts and pending results.
// ----------------------------------------------------------------------------
module error_norm_accumulator #(
    parameter int MAX_ITEMS   = enacc_pkg::DEF_MAX_ITEMS,
    parameter int VALUE_WIDTH = enacc_pkg::DEF_VALUE_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [enacc_pkg::FIELD_W-1:0] i_computed_value,
    input  logic [enacc_pkg::FIELD_W-1:0] i_exact_value,
    input  logic                          i_last_item,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [enacc_pkg::FIELD_W-1:0] o_mean_abs_error,
    output logic [enacc_pkg::FIELD_W-1:0] o_rms_error,
    output logic [enacc_pkg::FIELD_W-1:0] o_max_abs_error,
    output logic [enacc_pkg::COUNT_W-1:0] o_pair_count,
    output logic                          o_count_overflow
);
    import enacc_pkg::*;

    logic push, q_ready, q_valid, q_pop;
    t_job push_job, q_job;

    enacc_front #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_ITEMS   (MAX_ITEMS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_computed_value (i_computed_value),
        .i_exact_value    (i_exact_value),
        .i_last_item      (i_last_item),
        .o_push           (push),
        .o_job            (push_job),
        .i_q_ready        (q_ready)
    );

    enacc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (q_pop)
    );

    enacc_back #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_ITEMS   (MAX_ITEMS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_job_valid      (q_valid),
        .i_job            (q_job),
        .o_job_pop        (q_pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_mean_abs_error (o_mean_abs_error),
        .o_rms_error      (o_rms_error),
        .o_max_abs_error  (o_max_abs_error),
        .o_pair_count     (o_pair_count),
        .o_count_overflow (o_count_overflow)
    );

endmodule

@@ verif/tb_error_norm_accumulator.sv @@
// ----------------------------------------------------------------------------
// tb_error_norm_accumulator
// Self-checking bench for the error norm accumulator. A queue of sample pairs
// feeds a clocked driver. Each accepted pair updates an in-bench model of the
// L1, L2 and L-infinity sums. A clocked monitor compares every result
// transaction with the oldest predicted norm set. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_error_norm_accumulator;

    localparam int FW         = enacc_pkg::FIELD_W;
    localparam int CW         = enacc_pkg::COUNT_W;
    localparam int SET_LIMIT  = enacc_pkg::DEF_MAX_ITEMS;
    localparam int VW         = enacc_pkg::DEF_VALUE_WIDTH;
    localparam int RAND_ITEMS = 690;
    localparam int DRAIN_WAIT = 400;

    typedef struct {
        logic [FW-1:0] computed;
        logic [FW-1:0] exact;
        logic          last;
        bit            hold_for_drain;
    } t_sample_pair;

    typedef struct {
        logic [FW-1:0] mean_abs;
        logic [FW-1:0] rms;
        logic [FW-1:0] max_abs;
        logic [CW-1:0] count;
        logic          overflow;
    } t_norm_set;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          o_ready;
    logic [FW-1:0] i_computed_value = '0;
    logic [FW-1:0] i_exact_value = '0;
    logic          i_last_item = 1'b0;
    logic          o_valid;
    logic          i_ready = 1'b0;
    logic [FW-1:0] o_mean_abs_error;
    logic [FW-1:0] o_rms_error;
    logic [FW-1:0] o_max_abs_error;
    logic [CW-1:0] o_pair_count;
    logic          o_count_overflow;

    t_sample_pair pending_pairs[$];
    t_norm_set    expected_norms[$];
    int           error_count = 0;

    // Running sums of the set that is being accumulated.
    logic [36:0]   abs_total = '0;
    logic [59:0]   square_total = '0;
    logic [FW-1:0] peak_error = '0;
    logic [CW-1:0] pairs_kept = '0;
    logic          pairs_dropped = 1'b0;

    int send_gap = 0;
    int send_calm = 0;
    int recv_stall = 0;
    int recv_calm = 0;

    error_norm_accumulator dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_computed_value (i_computed_value),
        .i_exact_value    (i_exact_value),
        .i_last_item      (i_last_item),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_mean_abs_error (o_mean_abs_error),
        .o_rms_error      (o_rms_error),
        .o_max_abs_error  (o_max_abs_error),
        .o_pair_count     (o_pair_count),
        .o_count_overflow (o_count_overflow)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint signed sample_value(logic [FW-1:0] raw);
        longint unsigned v;
        v = raw & ((64'd1 << VW) - 1);
        if (v[VW-1])
            return longint'(v) - (longint'(1) << VW);
        return longint'(v);
    endfunction

    function automatic longint unsigned floor_root(longint unsigned x);
        longint unsigned root;
        longint unsigned probe;
        longint unsigned rem;
        root = 0;
        rem = x;
        probe = 64'd1 << 62;
        while (probe > rem)
            probe >>= 2;
        while (probe != 0) begin
            if (rem >= root + probe) begin
                rem -= root + probe;
                root = (root >> 1) + probe;
            end else begin
                root >>= 1;
            end
            probe >>= 2;
        end
        return root;
    endfunction

    function automatic void accumulate_pair(logic [FW-1:0] comp, logic [FW-1:0] exact,
                                            logic last);
        longint signed   diff;
        logic [FW-1:0]   mag;
        logic [47:0]     mag_sq;
        longint unsigned mean_sq;
        t_norm_set       norms;
        if (pairs_kept < SET_LIMIT) begin
            diff = sample_value(comp) - sample_value(exact);
            mag = (diff < 0) ? FW'(-diff) : FW'(diff);
            mag_sq = 48'(mag) * 48'(mag);
            abs_total = abs_total + 37'(mag);
            square_total = square_total + 60'(mag_sq);
            if (mag > peak_error)
                peak_error = mag;
            pairs_kept = pairs_kept + 1'b1;
        end else begin
            pairs_dropped = 1'b1;
        end
        if (last) begin
            norms.mean_abs = '0;
            norms.rms = '0;
            if (pairs_kept != 0) begin
                norms.mean_abs = FW'(abs_total / pairs_kept);
                mean_sq = longint'(square_total / pairs_kept);
                norms.rms = FW'(floor_root(mean_sq));
            end
            norms.max_abs = peak_error;
            norms.count = pairs_kept;
            norms.overflow = pairs_dropped;
            expected_norms.insert(expected_norms.size(), norms);
            abs_total = '0;
            square_total = '0;
            peak_error = '0;
            pairs_kept = '0;
            pairs_dropped = 1'b0;
        end
    endfunction

    // Mostly no gap or a short one, a few long ones, and now and then a stretch without any.
    function automatic int pick_idle(inout int calm);
        int roll;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 60)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge i_clk) begin : drive_pairs
        t_sample_pair p;
        logic         show;
        logic         load;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready)
                accumulate_pair(i_computed_value, i_exact_value, i_last_item);
            show = i_valid && !o_ready;
            load = 1'b0;
            if (!show) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_pairs.size() != 0 &&
                             !(pending_pairs[0].hold_for_drain &&
                               expected_norms.size() != 0)) begin
                    p = pending_pairs.pop_front();
                    show = 1'b1;
                    load = 1'b1;
                    send_gap = pick_idle(send_calm);
                end
            end
            i_valid <= show;
            if (load) begin
                i_computed_value <= p.computed;
                i_exact_value <= p.exact;
                i_last_item <= p.last;
            end
        end
    end

    always @(posedge i_clk) begin : watch_results
        t_norm_set want;
        logic      rdy;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_norms.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected result: mean %h rms %h max %h n %0d ovf %b",
                                 o_mean_abs_error, o_rms_error, o_max_abs_error,
                                 o_pair_count, o_count_overflow);
                end else begin
                    want = expected_norms.pop_front();
                    if (o_mean_abs_error !== want.mean_abs || o_rms_error !== want.rms ||
                        o_max_abs_error !== want.max_abs || o_pair_count !== want.count ||
                        o_count_overflow !== want.overflow) begin
                        error_count++;
                        if (error_count <= 10) begin
                            $display("mismatch: expected mean %h rms %h max %h n %0d ovf %b",
                                     want.mean_abs, want.rms, want.max_abs, want.count,
                                     want.overflow);
                            $display("          actual   mean %h rms %h max %h n %0d ovf %b",
                                     o_mean_abs_error, o_rms_error, o_max_abs_error,
                                     o_pair_count, o_count_overflow);
                        end
                    end
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                rdy = 1'b0;
            end else begin
                recv_stall = pick_idle(recv_calm);
                rdy = (recv_stall == 0);
            end
            i_ready <= rdy;
        end
    end

    task automatic add_pair(logic [FW-1:0] comp, logic [FW-1:0] exact, logic last,
                            bit hold = 1'b0);
        t_sample_pair p;
        p.computed = comp;
        p.exact = exact;
        p.last = last;
        p.hold_for_drain = hold;
        pending_pairs.insert(pending_pairs.size(), p);
    endtask

    function automatic logic [FW-1:0] corner_sample();
        case ($urandom_range(0, 5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'h000000;
            3: return 24'h000001;
            4: return 24'hFFFFFF;
            default: return FW'($urandom);
        endcase
    endfunction

    // flavor: 0 full range, 1 corner values, 2 close pairs.
    task automatic add_set(int n, int flavor, bit hold = 1'b0);
        logic [FW-1:0] c;
        logic [FW-1:0] e;
        for (int k = 0; k < n; k++) begin
            case (flavor)
                0: begin
                    c = FW'($urandom);
                    e = FW'($urandom);
                end
                1: begin
                    c = corner_sample();
                    e = corner_sample();
                end
                default: begin
                    c = FW'($urandom);
                    e = c + FW'($urandom_range(0, 512)) - FW'(256);
                end
            endcase
            add_pair(c, e, k == n - 1, hold && k == 0);
        end
    endtask

    initial begin : run_test
        int queued;
        int n;
        int roll;

        // Largest difference in both directions, zero and equal extremes.
        add_pair(24'h7FFFFF, 24'h800000, 1'b1);
        add_pair(24'h800000, 24'h7FFFFF, 1'b1);
        add_pair(24'h000000, 24'h000000, 1'b1);
        add_pair(24'h800000, 24'h800000, 1'b1);
        add_pair(24'h123456, 24'h123456, 1'b0);
        add_pair(24'hFFFFFF, 24'h000001, 1'b0);
        add_pair(24'h000001, 24'hFFFFFF, 1'b1);
        add_pair(24'h7FFFFF, 24'h000000, 1'b0);
        add_pair(24'h000000, 24'h800000, 1'b0);
        add_pair(24'hAAAAAA, 24'h555555, 1'b0);
        add_pair(24'h555555, 24'hAAAAAA, 1'b1);
        add_pair(24'h000001, 24'h000000, 1'b0);
        add_pair(24'h000000, 24'h000000, 1'b1);

        // This set waits until every earlier result has been received.
        add_set(40, 0, 1'b1);

        queued = 0;
        while (queued < RAND_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 80)
                n = $urandom_range(1, 8);
            else if (roll < 95)
                n = $urandom_range(9, 40);
            else
                n = $urandom_range(41, 200);
            add_set(n, $urandom_range(0, 2), $urandom_range(0, 39) == 0);
            queued += n;
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk); while (pending_pairs.size() != 0 || i_valid);
        do @(posedge i_clk); while (expected_norms.size() != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (error_count == 0)
            $display("** error_norm_accumulator: PASSED **");
        else
            $display("** error_norm_accumulator: FAILED **");
        $finish;
    end

    initial begin : watchdog
        #20000000;
        $display("** error_norm_accumulator: FAILED **");
        $finish;
    end

endmodule
